// ----- src/servo_sweep_pulse_sequencer_macros.svh -----
// Assertion helpers shared by the sequencer RTL.
`ifndef SERVO_SWEEP_PULSE_SEQUENCER_MACROS_SVH
`define SERVO_SWEEP_PULSE_SEQUENCER_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define SSPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, also skipped where reset was high at the previous clock edge.
`define SSPS_ASSERT_SETTLED(label, clk, rst, prop, msg) \
   `SSPS_ASSERT(label, clk, rst, (!$past(rst) |-> (prop)), msg)

`endif

// ----- src/sspseq_pkg.sv -----
package sspseq_pkg;

   // Frame ticks per second of dwell.
   localparam int unsigned TICKS_PER_SECOND_DEFAULT = 32;

   // Register limits and reset values.
   localparam int unsigned DWELL_MAX   = 65535;
   localparam logic [6:0]  SWING_MAX   = 7'd90;
   localparam logic [6:0]  SWING_RESET = 7'd45;
   localparam logic [15:0] DWELL_RESET = 16'd1;

   // Pulse widths in microseconds.
   localparam logic [10:0] PULSE_CENTER   = 11'd1499;
   localparam logic [10:0] PULSE_SIDE_A   = 11'd999;
   localparam logic [10:0] PULSE_SIDE_B   = 11'd1000;
   localparam logic [10:0] PULSE_MIN      = 11'd999;
   localparam logic [10:0] PULSE_MAX      = 11'd1999;

   // Fixed-point scale: slightly above 50 * 2^16 / 9; the side B bias folds in the -9 / 18 trim.
   localparam logic [26:0] PULSE_SCALE    = 27'd364100;
   localparam logic [26:0] SIDE_B_BIAS    = 27'd32769;

   typedef enum logic [1:0] {
      CSR_SWING_ANGLE   = 2'd0,
      CSR_DWELL_SECONDS = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_CENTER_A = 2'd0,
      PHASE_SIDE_A   = 2'd1,
      PHASE_CENTER_B = 2'd2,
      PHASE_SIDE_B   = 2'd3
   } phase_type;

endpackage

// ----- src/sspseq_pulse.sv -----
module sspseq_pulse
   import sspseq_pkg::*;
(
   input  logic [6:0]  swing_angle,
   input  phase_type   phase,
   output logic [10:0] pulse_width_us
);

   logic [6:0]  angle_eff;
   logic [7:0]  operand;
   logic [26:0] product;
   logic [26:0] scaled;

   // Clamp the swing to a quarter turn
   assign angle_eff = (swing_angle > SWING_MAX) ? SWING_MAX : swing_angle;

   // Side A uses 90 - a, side B uses 90 + a; one shared scale multiply
   assign operand = (phase == PHASE_SIDE_B) ? ({1'b0, SWING_MAX} + {1'b0, angle_eff})
                                            : ({1'b0, SWING_MAX} - {1'b0, angle_eff});
   assign product = {19'd0, operand} * PULSE_SCALE;
   assign scaled  = (phase == PHASE_SIDE_B) ? (product - SIDE_B_BIAS) : product;

   // Select the width for the phase
   always_comb begin
      case (phase)
         PHASE_SIDE_A: pulse_width_us = PULSE_SIDE_A + scaled[26:16];
         PHASE_SIDE_B: pulse_width_us = PULSE_SIDE_B + scaled[26:16];
         default:      pulse_width_us = PULSE_CENTER;
      endcase
   end

endmodule

// ----- src/servo_sweep_pulse_sequencer.sv -----
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_tick
// rsp       out        rsp_valid / rsp_stall  rsp_pulse_width_us, rsp_sweep_phase,
//                                             rsp_phase_advanced
// csr       in         csr_valid / csr_ready  csr_index, csr_data
//
// One transaction per cycle unless a result is stalled; a result appears the cycle
// after its request is taken, from the single register after the pulse multiplier.
// Reset returns the sweep to phase 0, clears the tick counter, swing 45, dwell 1 s.
// A stalled result holds the request side while rsp_stall stays high.
`include "servo_sweep_pulse_sequencer_macros.svh"

module servo_sweep_pulse_sequencer
   import sspseq_pkg::*;
#(
   parameter int unsigned TicksPerSecond = TICKS_PER_SECOND_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_tick,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_pulse_width_us,
   output logic [1:0]  rsp_sweep_phase,
   output logic        rsp_phase_advanced,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int unsigned CntWidth = $clog2(DWELL_MAX * TicksPerSecond + 1);

   logic [6:0]          swing_ff;
   logic [15:0]         dwell_ff;
   phase_type           phase_ff, phase_in;
   logic [CntWidth-1:0] count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [10:0]         pulse_ff;
   phase_type           rsp_phase_ff;
   logic                advanced_ff, advanced_in;

   logic                req_accept;
   logic [15:0]         dwell_eff;
   logic [CntWidth-1:0] period;
   logic [CntWidth:0]   count_inc;
   logic                wrap;
   logic [10:0]         pulse_width;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         swing_ff <= SWING_RESET;
         dwell_ff <= DWELL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SWING_ANGLE:   swing_ff <= csr_data[6:0];
            CSR_DWELL_SECONDS: dwell_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Hold requests only while a result waits and is stalled
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Phase period in ticks; zero dwell acts as one second
   assign dwell_eff = (dwell_ff == 16'd0) ? 16'd1 : dwell_ff;
   assign period    = CntWidth'(dwell_eff) * CntWidth'(TicksPerSecond);
   assign count_inc = {1'b0, count_ff} + {{CntWidth{1'b0}}, 1'b1};
   assign wrap      = count_inc >= {1'b0, period};

   sspseq_pulse u_pulse (
      .swing_angle    (swing_ff),
      .phase          (phase_ff),
      .pulse_width_us (pulse_width)
   );

   // Advance the tick counter and the sweep phase
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      advanced_in = 1'b0;
      if (req_accept && req_tick) begin
         if (wrap) begin
            count_in    = '0;
            phase_in    = phase_type'(phase_ff + 2'd1);
            advanced_in = 1'b1;
         end else begin
            count_in = count_inc[CntWidth-1:0];
         end
      end
   end

   // Result valid: load on accept, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_CENTER_A;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pulse_ff     <= pulse_width;
         rsp_phase_ff <= phase_ff;
         advanced_ff  <= advanced_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pulse_width_us = pulse_ff;
   assign rsp_sweep_phase    = rsp_phase_ff;
   assign rsp_phase_advanced = advanced_ff;

   `SSPS_ASSERT(a_phase_step, clock, reset, ((req_accept && req_tick && wrap) |=> (phase_ff == phase_type'($past(phase_ff) + 2'd1))), "phase did not step on wrap")
   `SSPS_ASSERT(a_count_bound, clock, reset, ((req_accept && req_tick) |=> (count_ff < $past(period))), "tick count not below period")
   `SSPS_ASSERT(a_idle_hold, clock, reset, ((req_accept && !req_tick) |=> ((count_ff == $past(count_ff)) && (phase_ff == $past(phase_ff)))), "idle request changed state")
   `SSPS_ASSERT_SETTLED(a_pulse_range, clock, reset, (rsp_valid |-> ((rsp_pulse_width_us >= PULSE_MIN) && (rsp_pulse_width_us <= PULSE_MAX))), "pulse width out of range")

endmodule
